>>> hdl/lmts_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix text scroller package
// Operation codes, field widths and the 5x7 font table shared by the
// scroller and its port checker.
// ----------------------------------------------------------------------------
package lmts_pkg;

  // Operation carried in the input tuser field
  typedef enum logic [2:0] {
    OP_WRITE_CHAR  = 3'd0,
    OP_SCROLL_STEP = 3'd1,
    OP_SHIFT_LEFT  = 3'd2,
    OP_SHIFT_RIGHT = 3'd3,
    OP_SHIFT_UP    = 3'd4,
    OP_SHIFT_DOWN  = 3'd5,
    OP_REFRESH     = 3'd6,
    OP_PUSH_COLUMN = 3'd7
  } lmts_op_t;

  localparam int ROW_W       = 7;
  localparam int IDX_W       = 5;
  localparam int SCAN_COL_W  = 5;
  localparam int GLYPH_W     = 3;
  localparam int GLYPH_WIDTH = 5;
  localparam int FIRST_CODE  = 32;
  localparam int GLYPH_COUNT = 94;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // One glyph per entry, column 0 in the top seven bits
  localparam logic [34:0] FONT_ROM [GLYPH_COUNT] = '{
    {7'h00,7'h00,7'h00,7'h00,7'h00}, {7'h00,7'h00,7'h7D,7'h00,7'h00},
    {7'h00,7'h60,7'h00,7'h60,7'h00}, {7'h22,7'h7F,7'h22,7'h7F,7'h22},
    {7'h3A,7'h2A,7'h7F,7'h2A,7'h2E}, {7'h11,7'h02,7'h04,7'h08,7'h11},
    {7'h36,7'h49,7'h49,7'h3F,7'h09}, {7'h00,7'h00,7'h60,7'h00,7'h00},
    {7'h3E,7'h41,7'h41,7'h00,7'h00}, {7'h00,7'h00,7'h41,7'h41,7'h3E},
    {7'h04,7'h15,7'h0E,7'h15,7'h04}, {7'h04,7'h04,7'h1F,7'h04,7'h04},
    {7'h02,7'h01,7'h00,7'h00,7'h00}, {7'h08,7'h08,7'h08,7'h08,7'h08},
    {7'h01,7'h00,7'h00,7'h00,7'h00}, {7'h01,7'h02,7'h04,7'h08,7'h10},
    {7'h3E,7'h45,7'h49,7'h51,7'h3E}, {7'h41,7'h41,7'h7F,7'h01,7'h01},
    {7'h47,7'h49,7'h49,7'h49,7'h31}, {7'h41,7'h49,7'h49,7'h49,7'h36},
    {7'h78,7'h08,7'h08,7'h08,7'h7F}, {7'h79,7'h49,7'h49,7'h49,7'h46},
    {7'h3E,7'h49,7'h49,7'h49,7'h06}, {7'h60,7'h40,7'h40,7'h40,7'h7F},
    {7'h36,7'h49,7'h49,7'h49,7'h36}, {7'h30,7'h49,7'h49,7'h49,7'h3E},
    {7'h00,7'h00,7'h12,7'h00,7'h00}, {7'h12,7'h01,7'h00,7'h00,7'h00},
    {7'h00,7'h08,7'h14,7'h22,7'h00}, {7'h00,7'h14,7'h14,7'h14,7'h14},
    {7'h00,7'h22,7'h14,7'h08,7'h00}, {7'h20,7'h40,7'h4D,7'h48,7'h30},
    {7'h7F,7'h41,7'h5D,7'h45,7'h7C},
    {7'h3F,7'h44,7'h44,7'h44,7'h3F}, {7'h7F,7'h49,7'h49,7'h39,7'h06},
    {7'h3E,7'h41,7'h41,7'h41,7'h22}, {7'h41,7'h7F,7'h41,7'h41,7'h3E},
    {7'h7F,7'h49,7'h49,7'h49,7'h49}, {7'h7F,7'h48,7'h48,7'h48,7'h48},
    {7'h3E,7'h41,7'h49,7'h49,7'h2E}, {7'h7F,7'h08,7'h08,7'h08,7'h7F},
    {7'h41,7'h41,7'h7F,7'h41,7'h41}, {7'h42,7'h41,7'h41,7'h41,7'h7E},
    {7'h7F,7'h08,7'h14,7'h22,7'h41}, {7'h7F,7'h01,7'h01,7'h01,7'h01},
    {7'h7F,7'h20,7'h10,7'h20,7'h7F}, {7'h7F,7'h10,7'h08,7'h04,7'h7F},
    {7'h3E,7'h41,7'h41,7'h41,7'h3E}, {7'h7F,7'h48,7'h48,7'h48,7'h30},
    {7'h3E,7'h41,7'h4D,7'h43,7'h3E}, {7'h7F,7'h48,7'h48,7'h4C,7'h33},
    {7'h32,7'h49,7'h49,7'h49,7'h26}, {7'h40,7'h40,7'h7F,7'h40,7'h40},
    {7'h7E,7'h01,7'h01,7'h01,7'h7E}, {7'h78,7'h06,7'h01,7'h06,7'h78},
    {7'h7F,7'h02,7'h04,7'h02,7'h7F}, {7'h63,7'h14,7'h08,7'h14,7'h63},
    {7'h70,7'h08,7'h07,7'h08,7'h70}, {7'h43,7'h45,7'h49,7'h51,7'h61},
    {7'h7F,7'h41,7'h41,7'h00,7'h00}, {7'h10,7'h08,7'h04,7'h02,7'h01},
    {7'h00,7'h00,7'h41,7'h41,7'h7F}, {7'h08,7'h10,7'h20,7'h10,7'h08},
    {7'h00,7'h01,7'h01,7'h01,7'h00}, {7'h00,7'h40,7'h20,7'h00,7'h00},
    {7'h3F,7'h44,7'h44,7'h44,7'h3F}, {7'h7F,7'h49,7'h49,7'h39,7'h06},
    {7'h3E,7'h41,7'h41,7'h41,7'h22}, {7'h41,7'h7F,7'h41,7'h41,7'h3E},
    {7'h7F,7'h49,7'h49,7'h49,7'h49}, {7'h7F,7'h48,7'h48,7'h48,7'h48},
    {7'h3E,7'h41,7'h49,7'h49,7'h2E}, {7'h7F,7'h08,7'h08,7'h08,7'h7F},
    {7'h41,7'h41,7'h7F,7'h41,7'h41}, {7'h42,7'h41,7'h41,7'h41,7'h7E},
    {7'h7F,7'h08,7'h14,7'h22,7'h41}, {7'h7F,7'h01,7'h01,7'h01,7'h01},
    {7'h7F,7'h20,7'h10,7'h20,7'h7F}, {7'h7F,7'h10,7'h08,7'h04,7'h7F},
    {7'h3E,7'h41,7'h41,7'h41,7'h3E}, {7'h7F,7'h48,7'h48,7'h48,7'h30},
    {7'h3E,7'h41,7'h4D,7'h43,7'h3E}, {7'h7F,7'h48,7'h48,7'h4C,7'h33},
    {7'h32,7'h49,7'h49,7'h49,7'h26}, {7'h40,7'h40,7'h7F,7'h40,7'h40},
    {7'h7E,7'h01,7'h01,7'h01,7'h7E}, {7'h78,7'h06,7'h01,7'h06,7'h78},
    {7'h7F,7'h02,7'h04,7'h02,7'h7F}, {7'h63,7'h14,7'h08,7'h14,7'h63},
    {7'h70,7'h08,7'h07,7'h08,7'h70}, {7'h43,7'h45,7'h49,7'h51,7'h61},
    {7'h08,7'h77,7'h41,7'h41,7'h00}, {7'h00,7'h00,7'h7F,7'h00,7'h00},
    {7'h00,7'h41,7'h41,7'h77,7'h08}
  };

  // Column of a glyph; codes outside the font and columns past the glyph are blank.
  function automatic logic [ROW_W-1:0] glyph_bits(input logic [ROW_W-1:0] code,
                                                  input logic [GLYPH_W-1:0] col);
    logic [ROW_W-1:0] rom_idx;
    logic [34:0]      entry;
    logic [ROW_W-1:0] bits;
    rom_idx = code - ROW_W'(FIRST_CODE);
    entry   = '0;
    bits    = '0;
    if ((code >= ROW_W'(FIRST_CODE)) && (code < ROW_W'(FIRST_CODE + GLYPH_COUNT))) begin
      entry = FONT_ROM[rom_idx];
    end
    case (col)
      3'd0:    bits = entry[34:28];
      3'd1:    bits = entry[27:21];
      3'd2:    bits = entry[20:14];
      3'd3:    bits = entry[13:7];
      3'd4:    bits = entry[6:0];
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

>>> hdl/led_matrix_text_scroller.sv
// ----------------------------------------------------------------------------
// LED matrix text scroller
// Column buffer, text store and 5x7 font lookup for a scrolling LED column
// matrix; refresh ticks return the row bits of the next scanned column.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_*      sink       one operation per transaction (op in tuser)
//  out_*     source     scanned column and its row bits, one per refresh tick
//
//  Every operation completes in the cycle it is accepted: state registers
//  update at that edge, and a refresh result appears in the output register
//  on the following cycle. One transaction per cycle is sustained while the
//  output is not stalled. in_tready drops only while a refresh result sits unread
//  in the output register. Reset (synchronous, rst_n low) clears the column
//  buffer, the text store and all counters.
// ----------------------------------------------------------------------------
module led_matrix_text_scroller #(
  parameter int COLUMNS     = 32,
  parameter int TEXT_LENGTH = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: text_index[4:0], char_code[11:5], column_bits[18:12], zero fill
  input  logic [lmts_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: op[2:0]
  input  logic [2:0]                        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: scan_column[4:0], row_bits[11:5], zero fill
  output logic [lmts_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // tuser: frame_start[0]
  output logic                              out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready
);
  import lmts_pkg::*;

  localparam int CPW  = (TEXT_LENGTH > 1) ? $clog2(TEXT_LENGTH) : 1;
  localparam int SPW  = $clog2(COLUMNS);

  // Input field decode
  logic                  in_accept;
  lmts_op_t              op;
  logic [IDX_W-1:0]      text_index;
  logic [ROW_W-1:0]      char_code;
  logic [ROW_W-1:0]      column_bits;
  logic [CPW+IDX_W-1:0]  text_index_ext;

  assign in_accept      = in_tvalid && in_tready;
  assign op             = lmts_op_t'(in_tuser);
  assign text_index     = in_tdata[4:0];
  assign char_code      = in_tdata[11:5];
  assign column_bits    = in_tdata[18:12];
  assign text_index_ext = {{CPW{1'b0}}, text_index};

  // State
  logic [ROW_W-1:0]   col_buf_r  [COLUMNS];
  logic [ROW_W-1:0]   col_buf_nxt[COLUMNS];
  logic [ROW_W-1:0]   text_r     [TEXT_LENGTH];
  logic [CPW-1:0]     char_pos_r, char_pos_nxt;
  logic [GLYPH_W-1:0] glyph_col_r, glyph_col_nxt;
  logic [SPW-1:0]     scan_pos_r, scan_pos_nxt;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tuser_r;

  // A new transaction is taken unless a result waits on a stalled output.
  assign in_tready = !out_tvalid_r || out_tready;

  // Scroll step: current character and the column it contributes
  logic [ROW_W-1:0] cur_code;
  logic             shift_in_en;
  logic [ROW_W-1:0] shift_in_val;

  assign cur_code = text_r[char_pos_r];

  always_comb begin
    shift_in_en   = 1'b0;
    shift_in_val  = '0;
    char_pos_nxt  = char_pos_r;
    glyph_col_nxt = glyph_col_r;
    scan_pos_nxt  = scan_pos_r;
    if (in_accept) begin
      unique case (op)
        OP_SCROLL_STEP: begin
          shift_in_en = 1'b1;
          if (cur_code == '0) begin
            // End of text: blank column, then restart at the first character.
            char_pos_nxt  = '0;
            glyph_col_nxt = '0;
          end else if (glyph_col_r >= GLYPH_W'(GLYPH_WIDTH)) begin
            // Spacer column after each character.
            glyph_col_nxt = '0;
            if (char_pos_r == CPW'(TEXT_LENGTH - 1)) begin
              char_pos_nxt = '0;
            end else begin
              char_pos_nxt = char_pos_r + 1'b1;
            end
          end else begin
            shift_in_val  = glyph_bits(cur_code, glyph_col_r);
            glyph_col_nxt = glyph_col_r + 1'b1;
          end
        end
        OP_SHIFT_LEFT: begin
          shift_in_en = 1'b1;
        end
        OP_PUSH_COLUMN: begin
          shift_in_en  = 1'b1;
          shift_in_val = column_bits;
        end
        OP_REFRESH: begin
          if (scan_pos_r == SPW'(COLUMNS - 1)) begin
            scan_pos_nxt = '0;
          end else begin
            scan_pos_nxt = scan_pos_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Column buffer next value: one move per column, all in parallel
  always_comb begin
    for (int i = 0; i < COLUMNS; i++) begin
      col_buf_nxt[i] = col_buf_r[i];
      if (shift_in_en) begin
        col_buf_nxt[i] = (i == COLUMNS - 1) ? shift_in_val : col_buf_r[(i + 1) % COLUMNS];
      end else if (in_accept && (op == OP_SHIFT_RIGHT)) begin
        col_buf_nxt[i] = (i == 0) ? '0 : col_buf_r[(i + COLUMNS - 1) % COLUMNS];
      end else if (in_accept && (op == OP_SHIFT_UP)) begin
        col_buf_nxt[i] = {col_buf_r[i][ROW_W-2:0], 1'b0};
      end else if (in_accept && (op == OP_SHIFT_DOWN)) begin
        col_buf_nxt[i] = {1'b0, col_buf_r[i][ROW_W-1:1]};
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COLUMNS; i++) begin
        col_buf_r[i] <= '0;
      end
      for (int j = 0; j < TEXT_LENGTH; j++) begin
        text_r[j] <= '0;
      end
      char_pos_r  <= '0;
      glyph_col_r <= '0;
      scan_pos_r  <= '0;
    end else begin
      for (int i = 0; i < COLUMNS; i++) begin
        col_buf_r[i] <= col_buf_nxt[i];
      end
      // Writes beyond the end of the text store are dropped.
      if (in_accept && (op == OP_WRITE_CHAR) && (int'(text_index) < TEXT_LENGTH)) begin
        text_r[text_index_ext[CPW-1:0]] <= char_code;
      end
      char_pos_r  <= char_pos_nxt;
      glyph_col_r <= glyph_col_nxt;
      scan_pos_r  <= scan_pos_nxt;
    end
  end

  // Refresh result: column index (low five bits), its row bits and frame flag
  logic [SPW+SCAN_COL_W-1:0] scan_ext;
  assign scan_ext = {{SCAN_COL_W{1'b0}}, scan_pos_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_accept && (op == OP_REFRESH)) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (op == OP_REFRESH)) begin
      out_tdata_r <= {4'b0, col_buf_r[scan_pos_r], scan_ext[SCAN_COL_W-1:0]};
      out_tuser_r <= (scan_pos_r == '0);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

>>> hdl/lmts_checker.sv
// ----------------------------------------------------------------------------
// LED matrix text scroller port checker
// Concurrent checks on the scroller's stream ports, bound to the top level.
// ----------------------------------------------------------------------------
module lmts_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic [2:0]                        in_tuser,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [lmts_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready
);
  import lmts_pkg::*;

  // A fresh result follows only an accepted refresh tick.
  a_result_from_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_tvalid && !($past(out_tvalid) && !$past(out_tready)))
      |-> $past(in_tvalid && in_tready && (in_tuser == OP_REFRESH)))
    else $error("result without an accepted refresh transaction");

  // A frame start is only ever flagged on column zero.
  a_frame_start_col0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[4:0] == 5'd0))
    else $error("frame start flagged on a nonzero column");

  // With no result pending, the block is always ready for a transaction.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  // A stalled result holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind led_matrix_text_scroller lmts_checker u_lmts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tuser   (in_tuser),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// LED matrix text scroller testbench
// Drives operations into the scroller through its input stream and keeps a
// cycle-free model of the column buffer, text store, scroll cursor and scan
// counter. Each refresh result is compared field by field with the model's
// prediction. Directed tests are followed by random traffic under several
// idle and stall profiles.
// ----------------------------------------------------------------------------
module tb;
  import lmts_pkg::*;

  localparam int COLUMNS     = 32;
  localparam int TEXT_LENGTH = 20;
  localparam int GLYPH_COLS  = 5;

  // One predicted refresh result
  typedef struct packed {
    logic [4:0] col;
    logic [6:0] rows;
    logic       frame;
  } scan_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;
  logic [2:0]              in_tuser   = '0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tuser;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;

  // Model state
  logic [6:0] pixel_cols [COLUMNS];
  logic [6:0] message [TEXT_LENGTH];
  int         msg_pos;
  int         glyph_pos;
  int         scan_pos;
  scan_t      expected_scans [$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int items_sent      = 0;
  int scans_checked   = 0;
  int frames_seen     = 0;
  int text_wraps      = 0;
  int error_count     = 0;

  led_matrix_text_scroller #(
    .COLUMNS    (COLUMNS),
    .TEXT_LENGTH(TEXT_LENGTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  // Clock: period of 8 time units
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // 5x7 font, column 0 in the top bits; lowercase letters reuse the capitals.
  function automatic logic [6:0] font_column(input logic [6:0] code, input int col);
    logic [34:0] g;
    g = '0;
    case (code)
      7'd33:         g = {7'h00, 7'h00, 7'h7D, 7'h00, 7'h00};
      7'd34:         g = {7'h00, 7'h60, 7'h00, 7'h60, 7'h00};
      7'd35:         g = {7'h22, 7'h7F, 7'h22, 7'h7F, 7'h22};
      7'd36:         g = {7'h3A, 7'h2A, 7'h7F, 7'h2A, 7'h2E};
      7'd37:         g = {7'h11, 7'h02, 7'h04, 7'h08, 7'h11};
      7'd38:         g = {7'h36, 7'h49, 7'h49, 7'h3F, 7'h09};
      7'd39:         g = {7'h00, 7'h00, 7'h60, 7'h00, 7'h00};
      7'd40:         g = {7'h3E, 7'h41, 7'h41, 7'h00, 7'h00};
      7'd41:         g = {7'h00, 7'h00, 7'h41, 7'h41, 7'h3E};
      7'd42:         g = {7'h04, 7'h15, 7'h0E, 7'h15, 7'h04};
      7'd43:         g = {7'h04, 7'h04, 7'h1F, 7'h04, 7'h04};
      7'd44:         g = {7'h02, 7'h01, 7'h00, 7'h00, 7'h00};
      7'd45:         g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
      7'd46:         g = {7'h01, 7'h00, 7'h00, 7'h00, 7'h00};
      7'd47:         g = {7'h01, 7'h02, 7'h04, 7'h08, 7'h10};
      7'd48:         g = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
      7'd49:         g = {7'h41, 7'h41, 7'h7F, 7'h01, 7'h01};
      7'd50:         g = {7'h47, 7'h49, 7'h49, 7'h49, 7'h31};
      7'd51:         g = {7'h41, 7'h49, 7'h49, 7'h49, 7'h36};
      7'd52:         g = {7'h78, 7'h08, 7'h08, 7'h08, 7'h7F};
      7'd53:         g = {7'h79, 7'h49, 7'h49, 7'h49, 7'h46};
      7'd54:         g = {7'h3E, 7'h49, 7'h49, 7'h49, 7'h06};
      7'd55:         g = {7'h60, 7'h40, 7'h40, 7'h40, 7'h7F};
      7'd56:         g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      7'd57:         g = {7'h30, 7'h49, 7'h49, 7'h49, 7'h3E};
      7'd58:         g = {7'h00, 7'h00, 7'h12, 7'h00, 7'h00};
      7'd59:         g = {7'h12, 7'h01, 7'h00, 7'h00, 7'h00};
      7'd60:         g = {7'h00, 7'h08, 7'h14, 7'h22, 7'h00};
      7'd61:         g = {7'h00, 7'h14, 7'h14, 7'h14, 7'h14};
      7'd62:         g = {7'h00, 7'h22, 7'h14, 7'h08, 7'h00};
      7'd63:         g = {7'h20, 7'h40, 7'h4D, 7'h48, 7'h30};
      7'd64:         g = {7'h7F, 7'h41, 7'h5D, 7'h45, 7'h7C};
      7'd65, 7'd97:  g = {7'h3F, 7'h44, 7'h44, 7'h44, 7'h3F};
      7'd66, 7'd98:  g = {7'h7F, 7'h49, 7'h49, 7'h39, 7'h06};
      7'd67, 7'd99:  g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
      7'd68, 7'd100: g = {7'h41, 7'h7F, 7'h41, 7'h41, 7'h3E};
      7'd69, 7'd101: g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h49};
      7'd70, 7'd102: g = {7'h7F, 7'h48, 7'h48, 7'h48, 7'h48};
      7'd71, 7'd103: g = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h2E};
      7'd72, 7'd104: g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
      7'd73, 7'd105: g = {7'h41, 7'h41, 7'h7F, 7'h41, 7'h41};
      7'd74, 7'd106: g = {7'h42, 7'h41, 7'h41, 7'h41, 7'h7E};
      7'd75, 7'd107: g = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
      7'd76, 7'd108: g = {7'h7F, 7'h01, 7'h01, 7'h01, 7'h01};
      7'd77, 7'd109: g = {7'h7F, 7'h20, 7'h10, 7'h20, 7'h7F};
      7'd78, 7'd110: g = {7'h7F, 7'h10, 7'h08, 7'h04, 7'h7F};
      7'd79, 7'd111: g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
      7'd80, 7'd112: g = {7'h7F, 7'h48, 7'h48, 7'h48, 7'h30};
      7'd81, 7'd113: g = {7'h3E, 7'h41, 7'h4D, 7'h43, 7'h3E};
      7'd82, 7'd114: g = {7'h7F, 7'h48, 7'h48, 7'h4C, 7'h33};
      7'd83, 7'd115: g = {7'h32, 7'h49, 7'h49, 7'h49, 7'h26};
      7'd84, 7'd116: g = {7'h40, 7'h40, 7'h7F, 7'h40, 7'h40};
      7'd85, 7'd117: g = {7'h7E, 7'h01, 7'h01, 7'h01, 7'h7E};
      7'd86, 7'd118: g = {7'h78, 7'h06, 7'h01, 7'h06, 7'h78};
      7'd87, 7'd119: g = {7'h7F, 7'h02, 7'h04, 7'h02, 7'h7F};
      7'd88, 7'd120: g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      7'd89, 7'd121: g = {7'h70, 7'h08, 7'h07, 7'h08, 7'h70};
      7'd90, 7'd122: g = {7'h43, 7'h45, 7'h49, 7'h51, 7'h61};
      7'd91:         g = {7'h7F, 7'h41, 7'h41, 7'h00, 7'h00};
      7'd92:         g = {7'h10, 7'h08, 7'h04, 7'h02, 7'h01};
      7'd93:         g = {7'h00, 7'h00, 7'h41, 7'h41, 7'h7F};
      7'd94:         g = {7'h08, 7'h10, 7'h20, 7'h10, 7'h08};
      7'd95:         g = {7'h00, 7'h01, 7'h01, 7'h01, 7'h00};
      7'd96:         g = {7'h00, 7'h40, 7'h20, 7'h00, 7'h00};
      7'd123:        g = {7'h08, 7'h77, 7'h41, 7'h41, 7'h00};
      7'd124:        g = {7'h00, 7'h00, 7'h7F, 7'h00, 7'h00};
      7'd125:        g = {7'h00, 7'h41, 7'h41, 7'h77, 7'h08};
      default:       g = '0;
    endcase
    if (col >= GLYPH_COLS) return 7'h00;
    return g[34 - 7*col -: 7];
  endfunction

  // Move every column one place toward index zero and fill the rightmost one.
  function automatic void shift_in(input logic [6:0] value);
    for (int i = 0; i < COLUMNS - 1; i++) pixel_cols[i] = pixel_cols[i + 1];
    pixel_cols[COLUMNS - 1] = value;
  endfunction

  // Update the model for one accepted operation and queue any scan result.
  function automatic void apply_scroller_op(input lmts_op_t op, input logic [4:0] idx,
                                            input logic [6:0] code,
                                            input logic [6:0] bits);
    scan_t      s;
    logic [6:0] ch;
    case (op)
      OP_WRITE_CHAR: begin
        if (idx < TEXT_LENGTH) message[idx] = code;
      end
      OP_SCROLL_STEP: begin
        ch = message[msg_pos];
        if (ch == 7'd0) begin
          // A zero character ends the text and restarts at the first one.
          shift_in(7'h00);
          msg_pos   = 0;
          glyph_pos = 0;
        end else if (glyph_pos >= GLYPH_COLS) begin
          // Spacer column, then on to the next character.
          shift_in(7'h00);
          msg_pos++;
          if (msg_pos >= TEXT_LENGTH) begin
            msg_pos = 0;
            text_wraps++;
          end
          glyph_pos = 0;
        end else begin
          shift_in(font_column(ch, glyph_pos));
          glyph_pos++;
        end
      end
      OP_SHIFT_LEFT: shift_in(7'h00);
      OP_SHIFT_RIGHT: begin
        for (int i = COLUMNS - 1; i > 0; i--) pixel_cols[i] = pixel_cols[i - 1];
        pixel_cols[0] = 7'h00;
      end
      OP_SHIFT_UP: begin
        for (int i = 0; i < COLUMNS; i++) pixel_cols[i] = {pixel_cols[i][5:0], 1'b0};
      end
      OP_SHIFT_DOWN: begin
        for (int i = 0; i < COLUMNS; i++) pixel_cols[i] = {1'b0, pixel_cols[i][6:1]};
      end
      OP_REFRESH: begin
        if (scan_pos >= COLUMNS) scan_pos = 0;
        s.col   = scan_pos[4:0];
        s.rows  = pixel_cols[scan_pos];
        s.frame = (scan_pos == 0);
        scan_pos++;
        expected_scans.push_back(s);
      end
      default: shift_in(bits);
    endcase
  endfunction

  // Input monitor and result checker. Both sample the values present at the
  // clock edge, before any of this edge's updates take effect.
  always @(posedge clk) begin : scan_check
    scan_t exp_s;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        apply_scroller_op(lmts_op_t'(in_tuser), in_tdata[4:0], in_tdata[11:5],
                          in_tdata[18:12]);
      if (out_tvalid && out_tready) begin
        if (expected_scans.size() == 0) begin
          $display("%0t: unexpected scan result col=%0d rows=%h frame=%b",
                   $time, out_tdata[4:0], out_tdata[11:5], out_tuser);
          error_count++;
        end else begin
          exp_s = expected_scans.pop_front();
          scans_checked++;
          if (exp_s.frame) frames_seen++;
          if (out_tdata[4:0] !== exp_s.col) begin
            $display("%0t: scan_column mismatch: expected %0d, actual %0d",
                     $time, exp_s.col, out_tdata[4:0]);
            error_count++;
          end
          if (out_tdata[11:5] !== exp_s.rows) begin
            $display("%0t: row_bits mismatch at column %0d: expected %h, actual %h",
                     $time, exp_s.col, exp_s.rows, out_tdata[11:5]);
            error_count++;
          end
          if (out_tuser !== exp_s.frame) begin
            $display("%0t: frame_start mismatch at column %0d: expected %b, actual %b",
                     $time, exp_s.col, exp_s.frame, out_tuser);
            error_count++;
          end
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one operation, with random idle cycles ahead of it, and wait until
  // the transaction is accepted.
  task automatic send_item(input lmts_op_t op, input logic [4:0] idx,
                           input logic [6:0] code, input logic [6:0] bits);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, bits, code, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!(op == OP_WRITE_CHAR && idx >= TEXT_LENGTH)) items_sent++;
  endtask

  // Every operation once, field extremes, ignored writes and a terminator.
  task automatic test_directed_ops();
    send_item(OP_WRITE_CHAR, 5'd0, 7'd65, 7'h00);
    send_item(OP_WRITE_CHAR, 5'd1, 7'd126, 7'h00);
    send_item(OP_WRITE_CHAR, 5'd19, 7'd125, 7'h00);
    send_item(OP_WRITE_CHAR, 5'd20, 7'd90, 7'h00);
    send_item(OP_WRITE_CHAR, 5'd31, 7'd127, 7'h7F);
    repeat (7) send_item(OP_SCROLL_STEP, 5'd0, 7'd0, 7'h00);
    send_item(OP_PUSH_COLUMN, 5'd0, 7'd0, 7'h7F);
    send_item(OP_PUSH_COLUMN, 5'd0, 7'd0, 7'h55);
    send_item(OP_PUSH_COLUMN, 5'd0, 7'd0, 7'h2A);
    send_item(OP_SHIFT_UP, 5'd0, 7'd0, 7'h00);
    send_item(OP_SHIFT_DOWN, 5'd0, 7'd0, 7'h00);
    send_item(OP_SHIFT_RIGHT, 5'd0, 7'd0, 7'h00);
    send_item(OP_SHIFT_LEFT, 5'd0, 7'd0, 7'h00);
    send_item(OP_WRITE_CHAR, 5'd0, 7'd0, 7'h00);
    send_item(OP_SCROLL_STEP, 5'd0, 7'd0, 7'h00);
    repeat (4) send_item(OP_REFRESH, 5'd0, 7'd0, 7'h00);
  endtask

  // A full text store with no terminator wraps back to the first character.
  task automatic test_unterminated_text();
    for (int i = 0; i < TEXT_LENGTH; i++)
      send_item(OP_WRITE_CHAR, 5'(i), 7'(33 + 4 * i), 7'h00);
    repeat (TEXT_LENGTH * (GLYPH_COLS + 1) + 8) begin
      send_item(OP_SCROLL_STEP, 5'd0, 7'd0, 7'h00);
      send_item(OP_REFRESH, 5'd0, 7'd0, 7'h00);
    end
  endtask

  // Fill the buffer with distinct columns and scan through it more than twice.
  task automatic test_scan_wrap();
    for (int i = 0; i < COLUMNS; i++)
      send_item(OP_PUSH_COLUMN, 5'd0, 7'd0, 7'((i * 37 + 5) & 7'h7F));
    repeat (2 * COLUMNS + 3) send_item(OP_REFRESH, 5'd0, 7'd0, 7'h00);
  endtask

  // Random traffic: about half messages followed by scrolling, plus runs of
  // refreshes near one frame long and unconstrained noise.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int start;
    int kind;
    int len;
    int steps;
    start           = items_sent;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    while (items_sent - start < n_items) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        len = $urandom_range(1, TEXT_LENGTH);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(4) != 0)
            send_item(OP_WRITE_CHAR, 5'(i), 7'($urandom_range(32, 126)), 7'h00);
          else
            send_item(OP_WRITE_CHAR, 5'(i), 7'($urandom_range(1, 127)), 7'h00);
        end
        if (len < TEXT_LENGTH && $urandom_range(3) != 0)
          send_item(OP_WRITE_CHAR, 5'(len), 7'd0, 7'h00);
        steps = $urandom_range(8, 64);
        repeat (steps) begin
          if ($urandom_range(9) == 0)
            send_item(lmts_op_t'($urandom_range(2, 7)), 5'd0, 7'd0,
                      7'($urandom_range(127)));
          send_item(OP_SCROLL_STEP, 5'd0, 7'd0, 7'h00);
          if ($urandom_range(1) == 0) send_item(OP_REFRESH, 5'd0, 7'd0, 7'h00);
        end
      end else if (kind < 8) begin
        repeat ($urandom_range(COLUMNS - 2, COLUMNS + 8))
          send_item(OP_REFRESH, 5'd0, 7'd0, 7'h00);
      end else begin
        repeat ($urandom_range(4, 16))
          send_item(lmts_op_t'($urandom_range(7)), 5'($urandom_range(31)),
                    7'($urandom_range(127)), 7'($urandom_range(127)));
      end
    end
  endtask

  // Main sequence
  initial begin
    for (int i = 0; i < COLUMNS; i++) pixel_cols[i] = 7'h00;
    for (int i = 0; i < TEXT_LENGTH; i++) message[i] = 7'h00;
    msg_pos   = 0;
    glyph_pos = 0;
    scan_pos  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_unterminated_text();
    test_scan_wrap();
    test_random_traffic(0, 0, 300);
    test_random_traffic(86, 0, 300);
    test_random_traffic(0, 86, 300);
    test_random_traffic(9, 9, 300);
    in_tvalid      <= 1'b0;
    recv_stall_pct  = 0;

    // Drain outstanding results, then wait for any stray output.
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d operations; checked %0d scan results over %0d frame starts.",
             items_sent, scans_checked, frames_seen);
    $display("Text wrapped past the end of the store %0d times; %0d mismatches.",
             text_wraps, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(8 * 400000);
    $display("Timeout: %0d scan results still outstanding", expected_scans.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
